FILE: rtl/ppm_pkg.sv
`default_nettype none
package ppm_pkg;

  // default sizing, handed to the top level parameters
  localparam int DIM_BITS_DEF   = 16;
  localparam int MAX_DIGITS_DEF = 3;

  // header number accumulator, saturating
  localparam int            ACC_W   = 17;
  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  // largest legal max value
  localparam logic [ACC_W-1:0] MAXVAL_LIMIT = ACC_W'(255);

  // characters of interest
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_3    = 8'h33;
  localparam logic [7:0] CH_6    = 8'h36;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;

  // parser phases
  typedef enum logic [8:0] {
    PH_MAGIC_P = 9'b000000001,
    PH_MAGIC_N = 9'b000000010,
    PH_SEP     = 9'b000000100,
    PH_SKIP    = 9'b000001000,
    PH_COMMENT = 9'b000010000,
    PH_NUMBER  = 9'b000100000,
    PH_P6      = 9'b001000000,
    PH_P3      = 9'b010000000,
    PH_HALT    = 9'b100000000
  } phase_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  // error codes
  typedef enum logic [3:0] {
    ERR_BAD_MAGIC  = 4'd0,
    ERR_NO_SEP     = 4'd1,
    ERR_EARLY_END  = 4'd2,
    ERR_BAD_DIM    = 4'd3,
    ERR_MAX_RANGE  = 4'd4,
    ERR_PIX_RANGE  = 4'd5,
    ERR_MISSING    = 4'd6,
    ERR_EXTRA      = 4'd7,
    ERR_BAD_TOKEN  = 4'd8
  } err_t;

  // one input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_end;
  } item_t;

  // one result item
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] img_width;
    logic [15:0] img_height;
    logic [7:0]  max_value;
    logic        is_ascii;
    err_t        error_code;
  } res_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || (c == 8'd9) || (c == 8'd10) ||
           (c == 8'd11) || (c == 8'd12) || (c == 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  // acc * 10 + d, saturating at the accumulator's top
  function automatic logic [ACC_W-1:0] acc_push(input logic [ACC_W-1:0] acc,
                                                input logic [3:0] d);
    logic [ACC_W+3:0] v;
    v = ((ACC_W+4)'(acc) << 3) + ((ACC_W+4)'(acc) << 1) + (ACC_W+4)'(d);
    return (v > (ACC_W+4)'(ACC_MAX)) ? ACC_MAX : v[ACC_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ppm_stream_parser.sv
// ppm stream parser: one byte or end event per transfer, at most one result each
// an input transfer reaches out_valid through the input register, then the result register
// throughput: one item per cycle while the result side keeps taking transfers
// a full result register stalls the input register, which then drops in_ready
// reset: rst_n synchronous active low; parser returns to waiting for the magic,
// header registers clear, both stages empty
`default_nettype none
module ppm_stream_parser #(
  parameter int DIM_BITS   = ppm_pkg::DIM_BITS_DEF,
  parameter int MAX_DIGITS = ppm_pkg::MAX_DIGITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_is_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [15:0]      out_img_width,
  output logic [15:0]      out_img_height,
  output logic [7:0]       out_max_value,
  output logic             out_is_ascii,
  output logic [3:0]       out_error_code
);
  import ppm_pkg::*;

  item_t in_item;
  item_t item_r;
  logic  item_vld_r;
  logic  step_en;
  logic  res_vld;
  res_t  res;
  res_t  res_r;

  assign in_item.data_byte = in_data_byte;
  assign in_item.is_end    = in_is_end;

  // held item advances when the result register can take a result
  assign step_en = item_vld_r && (!out_valid || out_ready);

  ppm_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (step_en),
    .vld_r    (item_vld_r),
    .item_r   (item_r)
  );

  ppm_core #(
    .DIM_BITS   (DIM_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (item_r),
    .res_vld (res_vld),
    .res     (res)
  );

  ppm_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_vld),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_r     (res_r)
  );

  // unpack result fields
  assign out_kind       = res_r.kind;
  assign out_red        = res_r.red;
  assign out_green      = res_r.green;
  assign out_blue       = res_r.blue;
  assign out_img_width  = res_r.img_width;
  assign out_img_height = res_r.img_height;
  assign out_max_value  = res_r.max_value;
  assign out_is_ascii   = res_r.is_ascii;
  assign out_error_code = res_r.error_code;

endmodule
`default_nettype wire

FILE: rtl/ppm_in_stage.sv
`default_nettype none
module ppm_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ppm_pkg::item_t in_item,
  input  wire logic          take,
  output logic               vld_r,
  output ppm_pkg::item_t     item_r
);
  import ppm_pkg::*;

  // room when empty or when the held item moves on this cycle
  assign in_ready = !vld_r || take;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  // payload capture on transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ppm_core.sv
`default_nettype none
module ppm_core #(
  parameter int DIM_BITS   = ppm_pkg::DIM_BITS_DEF,
  parameter int MAX_DIGITS = ppm_pkg::MAX_DIGITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step_en,
  input  wire ppm_pkg::item_t item,
  output logic                res_vld,
  output ppm_pkg::res_t       res
);
  import ppm_pkg::*;

  localparam int PL_W = 2 * DIM_BITS;
  localparam int DC_W = $clog2(MAX_DIGITS + 1);
  localparam logic [ACC_W-1:0] DIM_MAX = ACC_W'((1 << DIM_BITS) - 1);

  phase_t              phase_r, phase_nxt;
  logic                ascii_r, ascii_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [DC_W-1:0]     dcnt_r, dcnt_nxt;
  logic [DIM_BITS-1:0] width_r, width_nxt;
  logic [DIM_BITS-1:0] height_r, height_nxt;
  logic [7:0]          maxval_r, maxval_nxt;
  logic [1:0]          comp_r, comp_nxt;
  logic [7:0]          red_r, red_nxt;
  logic [7:0]          green_r, green_nxt;
  logic [PL_W-1:0]     left_r, left_nxt;

  logic [7:0]       c;
  logic [3:0]       dig;
  logic             take;
  logic [ACC_W-1:0] take_val;
  logic             emit;
  kind_t            kind;
  err_t             err;
  logic [7:0]       pix_b;
  logic [PL_W-1:0]  area;

  assign c    = item.data_byte;
  assign dig  = 4'(c - CH_0);
  assign area = PL_W'(width_r) * PL_W'(height_r);

  // one parse step
  always_comb begin
    phase_nxt  = phase_r;
    ascii_nxt  = ascii_r;
    acc_nxt    = acc_r;
    dcnt_nxt   = dcnt_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    maxval_nxt = maxval_r;
    comp_nxt   = comp_r;
    red_nxt    = red_r;
    green_nxt  = green_r;
    left_nxt   = left_r;
    take       = 1'b0;
    take_val   = '0;
    emit       = 1'b0;
    kind       = KIND_HEADER;
    err        = ERR_BAD_MAGIC;
    pix_b      = '0;

    if (phase_r == PH_HALT) begin
      emit = 1'b0;
    end else if (item.is_end) begin
      // end of stream
      emit      = 1'b1;
      phase_nxt = PH_HALT;
      if (phase_r == PH_P6 || phase_r == PH_P3) begin
        if (left_r == '0 && dcnt_r == '0) begin
          kind = KIND_DONE;
        end else begin
          kind = KIND_ERROR;
          err  = ERR_MISSING;
        end
      end else begin
        kind = KIND_ERROR;
        err  = ERR_EARLY_END;
      end
    end else begin
      case (phase_r)
        PH_MAGIC_P: begin
          if (c != CH_P) begin
            emit = 1'b1; kind = KIND_ERROR; err = ERR_BAD_MAGIC; phase_nxt = PH_HALT;
          end else begin
            phase_nxt = PH_MAGIC_N;
          end
        end
        PH_MAGIC_N: begin
          if (c == CH_3) begin
            ascii_nxt = 1'b1;
            phase_nxt = PH_SEP;
          end else if (c == CH_6) begin
            ascii_nxt = 1'b0;
            phase_nxt = PH_SEP;
          end else begin
            emit = 1'b1; kind = KIND_ERROR; err = ERR_BAD_MAGIC; phase_nxt = PH_HALT;
          end
        end
        PH_SEP: begin
          if (!is_ws(c)) begin
            emit = 1'b1; kind = KIND_ERROR; err = ERR_NO_SEP; phase_nxt = PH_HALT;
          end else begin
            comp_nxt  = 2'd0;
            phase_nxt = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (is_ws(c)) begin
            phase_nxt = PH_SKIP;
          end else if (c == CH_HASH) begin
            phase_nxt = PH_COMMENT;
          end else if (is_digit(c)) begin
            acc_nxt   = ACC_W'(dig);
            phase_nxt = PH_NUMBER;
          end else begin
            emit      = 1'b1;
            kind      = KIND_ERROR;
            err       = (comp_r == 2'd2) ? ERR_MAX_RANGE : ERR_BAD_DIM;
            phase_nxt = PH_HALT;
          end
        end
        PH_COMMENT: begin
          if (c == CH_LF) begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_NUMBER: begin
          if (is_digit(c)) begin
            acc_nxt = acc_push(acc_r, dig);
          end else if (!is_ws(c)) begin
            emit = 1'b1; kind = KIND_ERROR; err = ERR_NO_SEP; phase_nxt = PH_HALT;
          end else begin
            // header number complete
            acc_nxt = '0;
            if (comp_r == 2'd0) begin
              if (acc_r == '0 || acc_r > DIM_MAX) begin
                emit = 1'b1; kind = KIND_ERROR; err = ERR_BAD_DIM; phase_nxt = PH_HALT;
              end else begin
                width_nxt = acc_r[DIM_BITS-1:0];
                comp_nxt  = 2'd1;
                phase_nxt = PH_SKIP;
              end
            end else if (comp_r == 2'd1) begin
              if (acc_r > DIM_MAX) begin
                emit = 1'b1; kind = KIND_ERROR; err = ERR_BAD_DIM; phase_nxt = PH_HALT;
              end else begin
                height_nxt = acc_r[DIM_BITS-1:0];
                comp_nxt   = 2'd2;
                phase_nxt  = PH_SKIP;
              end
            end else begin
              if (acc_r > MAXVAL_LIMIT) begin
                emit = 1'b1; kind = KIND_ERROR; err = ERR_MAX_RANGE; phase_nxt = PH_HALT;
              end else begin
                maxval_nxt = acc_r[7:0];
                comp_nxt   = 2'd0;
                dcnt_nxt   = '0;
                left_nxt   = area;
                phase_nxt  = ascii_r ? PH_P3 : PH_P6;
                emit       = 1'b1;
                kind       = KIND_HEADER;
              end
            end
          end
        end
        PH_P6: begin
          if (left_r == '0) begin
            emit = 1'b1; kind = KIND_ERROR; err = ERR_EXTRA; phase_nxt = PH_HALT;
          end else begin
            take     = 1'b1;
            take_val = ACC_W'(c);
          end
        end
        PH_P3: begin
          if (is_ws(c)) begin
            if (dcnt_r != '0) begin
              dcnt_nxt = '0;
              acc_nxt  = '0;
              take     = 1'b1;
              take_val = acc_r;
            end
          end else if (dcnt_r == '0 && left_r == '0) begin
            emit = 1'b1; kind = KIND_ERROR; err = ERR_EXTRA; phase_nxt = PH_HALT;
          end else if (!is_digit(c) || dcnt_r >= DC_W'(MAX_DIGITS)) begin
            emit = 1'b1; kind = KIND_ERROR; err = ERR_BAD_TOKEN; phase_nxt = PH_HALT;
          end else begin
            acc_nxt  = acc_push(acc_r, dig);
            dcnt_nxt = dcnt_r + DC_W'(1);
          end
        end
        default: begin
          phase_nxt = PH_HALT;
        end
      endcase
    end

    // one color component accepted
    if (take) begin
      if (take_val > ACC_W'(maxval_r)) begin
        emit = 1'b1; kind = KIND_ERROR; err = ERR_PIX_RANGE; phase_nxt = PH_HALT;
      end else if (comp_r == 2'd0) begin
        red_nxt  = take_val[7:0];
        comp_nxt = 2'd1;
      end else if (comp_r == 2'd1) begin
        green_nxt = take_val[7:0];
        comp_nxt  = 2'd2;
      end else begin
        comp_nxt = 2'd0;
        left_nxt = left_r - PL_W'(1);
        emit     = 1'b1;
        kind     = KIND_PIXEL;
        pix_b    = take_val[7:0];
      end
    end
  end

  // result fields carry the updated header registers
  always_comb begin
    res_vld          = step_en && emit;
    res.kind         = kind;
    res.red          = (kind == KIND_PIXEL) ? red_r   : 8'd0;
    res.green        = (kind == KIND_PIXEL) ? green_r : 8'd0;
    res.blue         = pix_b;
    res.img_width    = 16'(width_nxt);
    res.img_height   = 16'(height_nxt);
    res.max_value    = maxval_nxt;
    res.is_ascii     = ascii_nxt;
    res.error_code   = (kind == KIND_ERROR) ? err : ERR_BAD_MAGIC;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_MAGIC_P;
      ascii_r  <= 1'b0;
      acc_r    <= '0;
      dcnt_r   <= '0;
      width_r  <= '0;
      height_r <= '0;
      maxval_r <= '0;
      comp_r   <= '0;
      red_r    <= '0;
      green_r  <= '0;
      left_r   <= '0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      ascii_r  <= ascii_nxt;
      acc_r    <= acc_nxt;
      dcnt_r   <= dcnt_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      maxval_r <= maxval_nxt;
      comp_r   <= comp_nxt;
      red_r    <= red_nxt;
      green_r  <= green_nxt;
      left_r   <= left_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ppm_out_stage.sv
`default_nettype none
module ppm_out_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load,
  input  wire ppm_pkg::res_t res,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ppm_pkg::res_t      res_r
);
  import ppm_pkg::*;

  // valid flag: set on load, cleared on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule
`default_nettype wire

FILE: sim/ppm_stream_parser_tb.sv
module ppm_stream_parser_tb;
  import ppm_pkg::*;

  localparam int unsigned DIM_LIMIT = (1 << DIM_BITS_DEF) - 1;
  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned ITEM_COUNT = 2000;

  // error field reads zero outside error results
  localparam err_t NO_ERR = ERR_BAD_MAGIC;

  // shape of the single file sent after reset
  typedef enum int {
    PLAN_CLEAN,
    PLAN_CUT,
    PLAN_EXTRA,
    PLAN_OVER_MAX,
    PLAN_BAD_TOKEN,
    PLAN_NO_ROWS,
    PLAN_HUGE,
    PLAN_FLIP_BYTE,
    PLAN_HEAD_CUT,
    PLAN_WIDE,
    PLAN_TALL,
    PLAN_BIG_MAX
  } plan_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_is_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [15:0] out_img_width;
  logic [15:0] out_img_height;
  logic [7:0]  out_max_value;
  logic        out_is_ascii;
  logic [3:0]  out_error_code;

  ppm_stream_parser dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_is_end      (in_is_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_img_width  (out_img_width),
    .out_img_height (out_img_height),
    .out_max_value  (out_max_value),
    .out_is_ascii   (out_is_ascii),
    .out_error_code (out_error_code)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // byte stream waiting to go out and results the parser owes
  item_t       byte_queue[$];
  res_t        expected_results[$];
  item_t       next_item;
  int unsigned items_total = 0;
  int unsigned items_taken = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;
  int unsigned in_wait = 0;
  int unsigned out_wait = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  // parser state as predicted
  phase_t      ph = PH_MAGIC_P;
  logic        ascii_q = 1'b0;
  logic [16:0] acc_q = '0;
  logic [2:0]  ndig_q = '0;
  logic [15:0] wd_q = '0;
  logic [15:0] ht_q = '0;
  logic [7:0]  mx_q = '0;
  logic [1:0]  slot_q = '0;
  logic [7:0]  red_q = '0;
  logic [7:0]  green_q = '0;
  logic [31:0] left_q = '0;

  function automatic bit is_blank(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  // decimal shift-in, clamped at the accumulator's top
  function automatic logic [16:0] grow_acc(input logic [16:0] a, input logic [7:0] c);
    logic [31:0] v;
    v = 32'(a) * 32'd10 + 32'(c - CH_0);
    return (v > 32'(ACC_MAX)) ? ACC_MAX : v[16:0];
  endfunction

  task automatic note_result(input kind_t k, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input err_t e);
    res_t res;
    res.kind       = k;
    res.red        = r;
    res.green      = g;
    res.blue       = b;
    res.img_width  = wd_q;
    res.img_height = ht_q;
    res.max_value  = mx_q;
    res.is_ascii   = ascii_q;
    res.error_code = e;
    expected_results.push_back(res);
  endtask

  task automatic halt_with(input err_t e);
    ph = PH_HALT;
    note_result(KIND_ERROR, 8'h00, 8'h00, 8'h00, e);
  endtask

  // one color component; the third of a triple makes a pixel
  task automatic add_sample(input logic [16:0] v);
    if (v > 17'(mx_q)) begin
      halt_with(ERR_PIX_RANGE);
    end else if (slot_q == 2'd0) begin
      red_q = v[7:0];
      slot_q = 2'd1;
    end else if (slot_q == 2'd1) begin
      green_q = v[7:0];
      slot_q = 2'd2;
    end else begin
      slot_q = 2'd0;
      left_q = left_q - 32'd1;
      note_result(KIND_PIXEL, red_q, green_q, v[7:0], NO_ERR);
    end
  endtask

  // header number done: width, height, then max value
  task automatic close_field();
    logic [16:0] v;
    v = acc_q;
    acc_q = '0;
    if (slot_q == 2'd0) begin
      if (v == '0 || v > 17'(DIM_LIMIT)) begin
        halt_with(ERR_BAD_DIM);
      end else begin
        wd_q = v[15:0];
        slot_q = 2'd1;
        ph = PH_SKIP;
      end
    end else if (slot_q == 2'd1) begin
      if (v > 17'(DIM_LIMIT)) begin
        halt_with(ERR_BAD_DIM);
      end else begin
        ht_q = v[15:0];
        slot_q = 2'd2;
        ph = PH_SKIP;
      end
    end else if (v > MAXVAL_LIMIT) begin
      halt_with(ERR_MAX_RANGE);
    end else begin
      mx_q = v[7:0];
      slot_q = 2'd0;
      ndig_q = '0;
      left_q = 32'(wd_q) * 32'(ht_q);
      ph = ascii_q ? PH_P3 : PH_P6;
      note_result(KIND_HEADER, 8'h00, 8'h00, 8'h00, NO_ERR);
    end
  endtask

  // advance the predicted parser by one accepted transfer
  task automatic parse_item(input logic [7:0] c, input logic fin);
    logic [16:0] v;
    if (ph == PH_HALT) return;
    if (fin) begin
      if (ph == PH_P6 || ph == PH_P3) begin
        if (left_q == '0 && ndig_q == '0) begin
          ph = PH_HALT;
          note_result(KIND_DONE, 8'h00, 8'h00, 8'h00, NO_ERR);
        end else begin
          halt_with(ERR_MISSING);
        end
      end else begin
        halt_with(ERR_EARLY_END);
      end
      return;
    end
    case (ph)
      PH_MAGIC_P: begin
        if (c != CH_P) halt_with(ERR_BAD_MAGIC);
        else ph = PH_MAGIC_N;
      end
      PH_MAGIC_N: begin
        if (c == CH_3) begin
          ascii_q = 1'b1;
          ph = PH_SEP;
        end else if (c == CH_6) begin
          ascii_q = 1'b0;
          ph = PH_SEP;
        end else begin
          halt_with(ERR_BAD_MAGIC);
        end
      end
      PH_SEP: begin
        if (!is_blank(c)) begin
          halt_with(ERR_NO_SEP);
        end else begin
          slot_q = 2'd0;
          ph = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (is_blank(c)) begin
          ph = PH_SKIP;
        end else if (c == CH_HASH) begin
          ph = PH_COMMENT;
        end else if (is_num(c)) begin
          acc_q = 17'(c - CH_0);
          ph = PH_NUMBER;
        end else if (slot_q == 2'd2) begin
          halt_with(ERR_MAX_RANGE);
        end else begin
          halt_with(ERR_BAD_DIM);
        end
      end
      PH_COMMENT: begin
        if (c == CH_LF) ph = PH_SKIP;
      end
      PH_NUMBER: begin
        if (is_num(c)) acc_q = grow_acc(acc_q, c);
        else if (!is_blank(c)) halt_with(ERR_NO_SEP);
        else close_field();
      end
      PH_P6: begin
        if (left_q == '0) halt_with(ERR_EXTRA);
        else add_sample(17'(c));
      end
      PH_P3: begin
        if (is_blank(c)) begin
          if (ndig_q != '0) begin
            ndig_q = '0;
            v = acc_q;
            acc_q = '0;
            add_sample(v);
          end
        end else if (ndig_q == '0 && left_q == '0) begin
          halt_with(ERR_EXTRA);
        end else if (!is_num(c) || ndig_q >= 3'(MAX_DIGITS_DEF)) begin
          halt_with(ERR_BAD_TOKEN);
        end else begin
          acc_q = grow_acc(acc_q, c);
          ndig_q = ndig_q + 3'd1;
        end
      end
      default: ph = PH_HALT;
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // stream building
  task automatic put_item(input logic [7:0] b, input logic fin);
    item_t it;
    it.data_byte = b;
    it.is_end = fin;
    byte_queue.push_back(it);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_item(s[i], 1'b0);
  endtask

  task automatic put_blanks(input int unsigned n);
    logic [7:0] b;
    repeat (n) begin
      case ($urandom_range(0, 5))
        0: b = 8'd9;
        1: b = 8'd10;
        2: b = 8'd11;
        3: b = 8'd12;
        4: b = 8'd13;
        default: b = 8'd32;
      endcase
      put_item(b, 1'b0);
    end
  endtask

  // comment line, always carrying all-zero and all-one bytes
  task automatic put_comment();
    logic [7:0] b;
    put_item(CH_HASH, 1'b0);
    put_item(8'h00, 1'b0);
    repeat ($urandom_range(0, 8)) begin
      b = 8'($urandom);
      if (b == CH_LF) b = CH_HASH;
      put_item(b, 1'b0);
    end
    put_item(8'hFF, 1'b0);
    put_item(CH_LF, 1'b0);
  endtask

  task automatic put_filler();
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 1) == 1) put_blanks($urandom_range(1, 3));
      else put_comment();
    end
  endtask

  task automatic put_number(input int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 3) == 0) s = {"00", s};
    put_text(s);
  endtask

  // one component: a decimal token in text mode, a raw byte otherwise
  task automatic put_sample(input int unsigned v, input bit text_mode);
    string s;
    if (text_mode) begin
      s = $sformatf("%0d", v);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(0, 3 - s.len())) s = {"0", s};
      put_text(s);
      put_blanks($urandom_range(1, 2));
    end else begin
      put_item(8'(v), 1'b0);
    end
  endtask

  function automatic int unsigned draw_sample(input int unsigned mx);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return mx;
      default: return $urandom_range(0, mx);
    endcase
  endfunction

  function automatic logic [7:0] any_solid(input bit no_digit);
    logic [7:0] b;
    b = 8'($urandom);
    while (is_blank(b) || (no_digit && is_num(b))) b = 8'($urandom);
    return b;
  endfunction

  // input side: one transfer at a time from the queue, random gaps
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_fire) begin
        in_wait = in_calm ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
      end
      if (!in_valid || in_fire) begin
        if (in_wait > 0) begin
          in_wait--;
          in_valid <= 1'b0;
        end else if (byte_queue.size() > 0) begin
          next_item = byte_queue.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= next_item.data_byte;
          in_is_end <= next_item.is_end;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side: random stall after each transfer
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fire) begin
        out_wait = out_calm ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
      end
      if (out_wait > 0) begin
        out_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // sample both channels, compare results, predict from inputs
  always @(posedge clk) begin
    res_t want;
    in_fire <= rst_n && in_valid && in_ready;
    out_fire <= rst_n && out_valid && out_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("out_kind: expected no result, actual %0d", out_kind);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("out_kind", want.kind, out_kind);
          check_field("out_red", want.red, out_red);
          check_field("out_green", want.green, out_green);
          check_field("out_blue", want.blue, out_blue);
          check_field("out_img_width", want.img_width, out_img_width);
          check_field("out_img_height", want.img_height, out_img_height);
          check_field("out_max_value", want.max_value, out_max_value);
          check_field("out_is_ascii", want.is_ascii, out_is_ascii);
          check_field("out_error_code", want.error_code, out_error_code);
        end
      end
      if (in_valid && in_ready) begin
        parse_item(in_data_byte, in_is_end);
        items_taken++;
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready)) idle_cycles++;
    else idle_cycles = 0;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("ppm_stream_parser_tb: done, errors");
      $finish;
    end
  end

  initial begin
    plan_t           plan;
    int unsigned     pick;
    int unsigned     wd;
    int unsigned     ht;
    int unsigned     mx;
    int unsigned     budget;
    int unsigned     ncomp;
    int unsigned     stop_at;
    int unsigned     k;
    longint unsigned area;
    bit              text_mode;

    // the parser stops for good after its first verdict, so one file per run
    pick = $urandom_range(0, 23);
    plan = (pick >= 12 && pick <= 22) ? plan_t'(pick - 11) : PLAN_CLEAN;
    text_mode = (plan == PLAN_BAD_TOKEN) ? 1'b1 : 1'($urandom_range(0, 1));
    budget = text_mode ? 160 : 640;

    // dimensions
    wd = $urandom_range(1, 40);
    ht = budget / wd;
    case (plan)
      PLAN_NO_ROWS: begin
        ht = 0;
        wd = ($urandom_range(0, 1) == 1) ? DIM_LIMIT : $urandom_range(1, DIM_LIMIT);
      end
      PLAN_HUGE: begin
        if ($urandom_range(0, 1) == 1) begin
          wd = DIM_LIMIT;
          ht = $urandom_range(1, DIM_LIMIT);
        end else begin
          wd = $urandom_range(1, DIM_LIMIT);
          ht = DIM_LIMIT;
        end
      end
      PLAN_WIDE: wd = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(DIM_LIMIT + 1, 9999999);
      PLAN_TALL: ht = $urandom_range(DIM_LIMIT + 1, 9999999);
      default: ;
    endcase

    // max value, kept below 255 where a pixel has to exceed it
    case ($urandom_range(0, 7))
      0: mx = 0;
      1, 2, 3: mx = $urandom_range(1, 254);
      default: mx = 255;
    endcase
    if (plan == PLAN_OVER_MAX && mx == 255) mx = $urandom_range(0, 254);
    if (plan == PLAN_BIG_MAX) mx = $urandom_range(256, 99999);

    // header with whitespace and comments between the numbers
    put_item(CH_P, 1'b0);
    put_item(text_mode ? CH_3 : CH_6, 1'b0);
    put_blanks(1);
    put_comment();
    put_filler();
    put_number(wd);
    put_blanks(1);
    put_filler();
    put_number(ht);
    put_blanks(1);
    put_filler();
    put_number(mx);
    put_blanks(1);

    // broken headers
    if (plan == PLAN_FLIP_BYTE) begin
      k = $urandom_range(0, byte_queue.size() - 1);
      byte_queue[k].data_byte = 8'($urandom);
    end
    if (plan == PLAN_HEAD_CUT) begin
      k = $urandom_range(0, byte_queue.size() - 2);
      while (byte_queue.size() > k + 1) void'(byte_queue.pop_back());
      put_item(8'($urandom), 1'b1);
    end

    // pixel data, capped for very large images
    area = 64'(wd) * 64'(ht);
    if (area > 64'(budget)) area = 64'(budget);
    ncomp = 3 * int'(area);
    case (plan)
      PLAN_HEAD_CUT, PLAN_WIDE, PLAN_TALL, PLAN_BIG_MAX: stop_at = 0;
      PLAN_CUT, PLAN_OVER_MAX, PLAN_BAD_TOKEN: stop_at = $urandom_range(0, ncomp - 1);
      default: stop_at = ncomp;
    endcase
    for (int i = 0; i < stop_at; i++) put_sample(draw_sample(mx), text_mode);

    // how the file ends
    case (plan)
      PLAN_HEAD_CUT, PLAN_WIDE, PLAN_TALL, PLAN_BIG_MAX: ;
      PLAN_CUT: begin
        if (text_mode && $urandom_range(0, 1) == 1)
          put_item(CH_0 + 8'($urandom_range(0, 9)), 1'b0);
        put_item(8'($urandom), 1'b1);
      end
      PLAN_EXTRA: begin
        put_item(text_mode ? any_solid(1'b0) : 8'($urandom), 1'b0);
        put_item(8'($urandom), 1'b1);
      end
      PLAN_OVER_MAX: put_sample($urandom_range(mx + 1, text_mode ? 999 : 255), text_mode);
      PLAN_BAD_TOKEN: begin
        if ($urandom_range(0, 1) == 1) begin
          repeat (4) put_item(CH_0 + 8'($urandom_range(0, 9)), 1'b0);
        end else begin
          repeat ($urandom_range(0, 2)) put_item(CH_0 + 8'($urandom_range(0, 9)), 1'b0);
          put_item(any_solid(1'b1), 1'b0);
        end
        put_blanks(1);
      end
      PLAN_NO_ROWS: begin
        if ($urandom_range(0, 1) == 1) put_item(any_solid(1'b0), 1'b0);
        put_item(8'($urandom), 1'b1);
      end
      default: begin
        if (text_mode) put_blanks($urandom_range(0, 2));
        put_item(8'($urandom), 1'b1);
      end
    endcase

    // traffic after the verdict must be swallowed; short files are padded out
    k = $urandom_range(10, 30);
    if (byte_queue.size() + k < ITEM_COUNT) k = ITEM_COUNT - byte_queue.size();
    repeat (k) put_item(8'($urandom), $urandom_range(0, 7) == 0);
    items_total = byte_queue.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (items_taken == items_total);
    wait (expected_results.size() == 0);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("ppm_stream_parser_tb: done, clean");
    end else begin
      $display("ppm_stream_parser_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/ppm_pkg.sv
rtl/ppm_in_stage.sv
rtl/ppm_core.sv
rtl/ppm_out_stage.sv
rtl/ppm_stream_parser.sv
sim/ppm_stream_parser_tb.sv
